// File: sv/npt_pkg.sv
// Shared types and codes for the node presence table.
// Used by npt_table, npt_cmp and node_presence_table_with_aging_top.
package npt_pkg;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

  typedef enum logic [1:0] {
    REQ_REPORT = 2'd0,
    REQ_SWEEP  = 2'd1,
    REQ_RD_IDX = 2'd2,
    REQ_RD_ID  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_SWEEP    = 3'd3,
    ST_FOUND    = 3'd4,
    ST_MISSING  = 3'd5
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LOOK     = 7'b0000010,
    S_RDX      = 7'b0000100,
    S_SW_CHK   = 7'b0001000,
    S_SW_MOVE  = 7'b0010000,
    S_SW_READ  = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [6:0]  id;
    logic [1:0]  health;
    logic [2:0]  mode;
    logic [31:0] uptime;
    logic [15:0] vendor;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    req_e        req_type;
    logic [6:0]  node_id;
    logic [3:0]  entry_index;
    logic [1:0]  health;
    logic [2:0]  mode;
    logic [31:0] uptime;
    logic [15:0] vendor;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  node_count;
    logic [4:0]  removed;
    logic [3:0]  found_index;
    entry_t      entry;
  } result_t;

  // compare unit flags
  typedef struct packed {
    logic id_hit;
    logic stale;
  } cmp_t;

endpackage

// File: sv/npt_table.sv
// Entry store of the presence table: one write port, one read port, registered read.
// Depends on npt_pkg for the entry layout.
module npt_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  npt_pkg::entry_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output npt_pkg::entry_t rd_data_o
);
  import npt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/npt_cmp.sv
// Shared compare unit: node id match and age-versus-timeout test on the entry read.
// Depends on npt_pkg.
module npt_cmp (
  input  npt_pkg::entry_t entry_i,
  input  logic [6:0]      node_id_i,
  input  logic [31:0]     now_i,
  input  logic [15:0]     timeout_i,
  output npt_pkg::cmp_t   flags_o
);
  import npt_pkg::*;

  logic [31:0] age;

  // age wraps modulo 2^32
  assign age            = now_i - entry_i.seen;
  assign flags_o.stale  = age > {16'd0, timeout_i};
  assign flags_o.id_hit = entry_i.id == node_id_i;

endmodule

// File: sv/node_presence_table_with_aging_top.sv
// Node presence table with aging. Report or lookup by id scans the stored entries in order,
// one entry per cycle through the table read port, until a hit or the end of the count; read
// by index reads one entry; sweep checks each entry and, for a stale one, moves the last entry
// into its place (S_SW_CHK, S_SW_MOVE, S_SW_READ) and checks it again. One item at a time: tready
// returns as the result enters the output register; S_OUT waits while the old result is not taken.
// Reset clears count, state and output valid; timeout returns to 3000 ms; table not cleared.
module node_presence_table_with_aging_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,      // stale_timeout_ms
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // node_id[6:0], entry_index[10:7], health[12:11], mode[15:13], uptime[47:16],
  // vendor_code[63:48], now_ms[95:64]
  input  logic [95:0]  s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,   // req_type[1:0]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // node_count[4:0], removed_count[9:5], found_index[13:10], entry_node_id[20:14],
  // entry_health[22:21], entry_mode[25:23], entry_uptime[57:26],
  // entry_vendor_code[73:58], entry_last_seen_ms[105:74], zero[111:106]
  output logic [111:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o    // status[2:0]
);
  import npt_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  state_e        state_q, state_d;
  req_t          req_q, req_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [15:0]   tmo_q;
  result_t       res_q, res_d;
  result_t       out_q;
  logic          out_valid_q;
  logic          out_load;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data, rd_data, new_entry;
  cmp_t          flags;
  req_t          in_req;

  assign in_req.req_type    = req_e'(s_axis_tuser_i);
  assign in_req.node_id     = s_axis_tdata_i[6:0];
  assign in_req.entry_index = s_axis_tdata_i[10:7];
  assign in_req.health      = s_axis_tdata_i[12:11];
  assign in_req.mode        = s_axis_tdata_i[15:13];
  assign in_req.uptime      = s_axis_tdata_i[47:16];
  assign in_req.vendor      = s_axis_tdata_i[63:48];
  assign in_req.now         = s_axis_tdata_i[95:64];

  assign new_entry.id     = req_q.node_id;
  assign new_entry.health = req_q.health;
  assign new_entry.mode   = req_q.mode;
  assign new_entry.uptime = req_q.uptime;
  assign new_entry.vendor = req_q.vendor;
  assign new_entry.seen   = req_q.now;

  npt_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  npt_cmp u_cmp (
    .entry_i   (rd_data),
    .node_id_i (req_q.node_id),
    .now_i     (req_q.now),
    .timeout_i (tmo_q),
    .flags_o   (flags)
  );

  assign s_axis_tready_o = state_q == S_IDLE;

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    i_d      = i_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    res_d    = res_q;
    rd_en    = 1'b0;
    rd_addr  = i_q[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = i_q[IW-1:0];
    wr_data  = rd_data;
    out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d   = in_req;
          i_d     = '0;
          rem_d   = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          case (in_req.req_type)
            REQ_SWEEP: state_d = S_SW_CHK;
            REQ_RD_IDX: begin
              rd_addr = IW'(in_req.entry_index);
              state_d = S_RDX;
            end
            default: state_d = S_LOOK;
          endcase
        end
      end

      S_LOOK: begin
        res_d            = '0;
        res_d.node_count = 5'(cnt_q);
        if (i_q >= cnt_q) begin
          state_d = S_OUT;
          if (req_q.req_type == REQ_REPORT) begin
            if (cnt_q < MAX_CNT) begin
              wr_en             = 1'b1;
              wr_addr           = cnt_q[IW-1:0];
              wr_data           = new_entry;
              cnt_d             = cnt_q + 1'b1;
              res_d.status      = ST_INSERTED;
              res_d.node_count  = 5'(cnt_q + 1'b1);
              res_d.found_index = 4'(cnt_q);
              res_d.entry       = new_entry;
            end else begin
              res_d.status = ST_FULL;
            end
          end else begin
            res_d.status = ST_MISSING;
          end
        end else if (flags.id_hit) begin
          state_d           = S_OUT;
          res_d.found_index = 4'(i_q);
          if (req_q.req_type == REQ_REPORT) begin
            wr_en        = 1'b1;
            wr_data      = new_entry;
            res_d.status = ST_UPDATED;
            res_d.entry  = new_entry;
          end else begin
            res_d.status = ST_FOUND;
            res_d.entry  = rd_data;
          end
        end else begin
          // prefetch next entry while this one is compared
          i_d     = i_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = IW'(i_q + 1'b1);
        end
      end

      S_RDX: begin
        res_d            = '0;
        res_d.node_count = 5'(cnt_q);
        if (8'(req_q.entry_index) < 8'(cnt_q)) begin
          res_d.status      = ST_FOUND;
          res_d.found_index = req_q.entry_index;
          res_d.entry       = rd_data;
        end else begin
          res_d.status = ST_MISSING;
        end
        state_d = S_OUT;
      end

      S_SW_CHK: begin
        if (i_q >= cnt_q) begin
          res_d            = '0;
          res_d.status     = ST_SWEEP;
          res_d.node_count = 5'(cnt_q);
          res_d.removed    = 5'(rem_q);
          state_d          = S_OUT;
        end else if (flags.stale) begin
          // fetch the last entry to fill the hole
          rd_en   = 1'b1;
          rd_addr = IW'(cnt_q - 1'b1);
          state_d = S_SW_MOVE;
        end else begin
          i_d     = i_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = IW'(i_q + 1'b1);
        end
      end

      S_SW_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        cnt_d   = cnt_q - 1'b1;
        rem_d   = rem_q + 1'b1;
        state_d = S_SW_READ;
      end

      S_SW_READ: begin
        // recheck the moved entry at the same position
        rd_en   = 1'b1;
        state_d = S_SW_CHK;
      end

      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      tmo_q       <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        tmo_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {6'd0, out_q.entry.seen, out_q.entry.vendor, out_q.entry.uptime,
                            out_q.entry.mode, out_q.entry.health, out_q.entry.id,
                            out_q.found_index, out_q.removed, out_q.node_count};

endmodule
